// ----- rtl/core/gdrc_pkg.sv -----
// Shared types, widths and constants for the grid ray caster core.
// Used by the RAM-free controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package gdrc_pkg;

    // Map defaults
    localparam int MAP_COLS_DEF   = 16;
    localparam int MAP_ROWS_DEF   = 16;
    localparam int TILE_KINDS_DEF = 3;

    // Fixed-point layout
    localparam int FRAC_BITS = 12;
    localparam int DIR_FRAC  = 14;
    localparam int ORG_W     = 16;
    localparam int DIR_W     = 16;
    localparam int COORD_W   = 17;
    localparam int DIST_W    = 40;
    localparam int LEN_W     = 16;
    localparam int QUO_W     = LEN_W + FRAC_BITS;
    localparam int RAD_W     = 32;
    localparam int CELL_W    = 12;
    localparam int MUL_A_W   = 16;
    localparam int MUL_B_W   = 30;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int OFF_W     = MUL_P_W - DIR_FRAC;
    localparam int LIMIT_W   = 8;
    localparam int IDX_W     = 8;
    localparam int KIND_OUT_W = 2;

    localparam logic [DIST_W-1:0]    DIST_MAX    = {DIST_W{1'b1}};
    localparam logic [COORD_W-1:0]   COORD_MAX   = {COORD_W{1'b1}};
    localparam logic [FRAC_BITS:0]   FRAC_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 8'd100;

    // Iteration counts of the shared units
    localparam int SQRT_STEPS = LEN_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Stream and register port widths
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_DIST_LIMIT = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_EDIT_RD,
        ST_EDIT_WR,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIRST_X,
        ST_FIRST_Y,
        ST_WALK_INIT,
        ST_STEP,
        ST_CHECK,
        ST_HIT_X,
        ST_HIT_Y,
        ST_HIT_SAVE,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        MUL_SQ_X,
        MUL_SQ_Y,
        MUL_FIRST_X,
        MUL_FIRST_Y,
        MUL_HIT_X,
        MUL_HIT_Y
    } t_mul_sel;

    typedef struct packed {
        logic     load_in;
        t_mul_sel mul_sel;
        logic     sq_save;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     first_x_save;
        logic     walk_init;
        logic     step;
        logic     edit_read;
        logic     edit_write;
        logic     hit_x_save;
        logic     hit_y_save;
        logic     res_miss;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic cast;
        logic at_limit;
        logic hit_found;
    } t_status;

endpackage

// ----- rtl/core/gdrc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gdrc_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/gdrc_ctrl.sv -----
// Sequencer for the ray caster: issues datapath commands per state.
// Depends on gdrc_pkg for the state, command and status types.
`timescale 1ns / 1ps

module gdrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  gdrc_pkg::t_status i_status,
    output gdrc_pkg::t_cmd   o_cmd
);
    import gdrc_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cmd             w_cmd;

    // State, counter and result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        w_cmd.mul_sel = MUL_SQ_X;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load_in = 1'b1;
                    n_state = ST_SQ_X;
                end
            end
            ST_SQ_X: begin
                // First cycle after the request: pick edit or cast
                if (!i_status.cast) begin
                    n_state = ST_EDIT_RD;
                end else begin
                    w_cmd.mul_sel = MUL_SQ_X;
                    n_state = ST_SQ_Y;
                end
            end
            ST_EDIT_RD: begin
                w_cmd.edit_read = 1'b1;
                n_state = ST_EDIT_WR;
            end
            ST_EDIT_WR: begin
                w_cmd.edit_write = 1'b1;
                n_state = ST_FINISH;
            end
            ST_SQ_Y: begin
                w_cmd.mul_sel = MUL_SQ_Y;
                w_cmd.sq_save = 1'b1;
                n_state = ST_SQRT_INIT;
            end
            ST_SQRT_INIT: begin
                w_cmd.sqrt_init = 1'b1;
                n_cnt = '0;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                w_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = ST_DIV_INIT;
                end
            end
            ST_DIV_INIT: begin
                w_cmd.div_init = 1'b1;
                n_cnt = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                w_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_FIRST_X;
                end
            end
            ST_FIRST_X: begin
                w_cmd.mul_sel = MUL_FIRST_X;
                n_state = ST_FIRST_Y;
            end
            ST_FIRST_Y: begin
                w_cmd.mul_sel = MUL_FIRST_Y;
                w_cmd.first_x_save = 1'b1;
                n_state = ST_WALK_INIT;
            end
            ST_WALK_INIT: begin
                w_cmd.walk_init = 1'b1;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                // Give up at the limit, else advance one cell and read it
                if (i_status.at_limit) begin
                    w_cmd.res_miss = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    w_cmd.step = 1'b1;
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.hit_found ? ST_HIT_X : ST_STEP;
            end
            ST_HIT_X: begin
                w_cmd.mul_sel = MUL_HIT_X;
                n_state = ST_HIT_Y;
            end
            ST_HIT_Y: begin
                w_cmd.mul_sel = MUL_HIT_Y;
                w_cmd.hit_x_save = 1'b1;
                n_state = ST_HIT_SAVE;
            end
            ST_HIT_SAVE: begin
                w_cmd.hit_y_save = 1'b1;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/core/gdrc_datapath.sv -----
// Datapath of the ray caster: map store, shared multiplier, square root,
// two-lane divider, cell walker and result registers. Uses gdrc_pkg and gdrc_ram.
`timescale 1ns / 1ps

module gdrc_datapath #(
    parameter int MAP_COLS   = gdrc_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS   = gdrc_pkg::MAP_ROWS_DEF,
    parameter int TILE_KINDS = gdrc_pkg::TILE_KINDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gdrc_pkg::t_cmd                 i_cmd,
    output gdrc_pkg::t_status              o_status,
    input  logic                           i_mode,
    input  logic [3:0]                     i_cell_column,
    input  logic [3:0]                     i_cell_row,
    input  logic [gdrc_pkg::ORG_W-1:0]     i_origin_x,
    input  logic [gdrc_pkg::ORG_W-1:0]     i_origin_y,
    input  logic signed [gdrc_pkg::DIR_W-1:0] i_dir_x,
    input  logic signed [gdrc_pkg::DIR_W-1:0] i_dir_y,
    input  logic                           i_cfg_we,
    input  logic [gdrc_pkg::LIMIT_W-1:0]   i_cfg_data,
    output logic [gdrc_pkg::LIMIT_W-1:0]   o_distance_limit,
    output logic                           o_hit,
    output logic [gdrc_pkg::IDX_W-1:0]     o_hit_cell_index,
    output logic [gdrc_pkg::KIND_OUT_W-1:0] o_hit_kind,
    output logic [gdrc_pkg::COORD_W-1:0]   o_hit_x,
    output logic [gdrc_pkg::COORD_W-1:0]   o_hit_y
);
    import gdrc_pkg::*;

    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(TILE_KINDS + 1);

    function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] hit_coord(input logic [ORG_W-1:0] org,
                                                     input logic neg,
                                                     input logic big,
                                                     input logic [MUL_P_W-1:0] prod);
        logic [OFF_W-1:0] off;
        logic [OFF_W+1:0] sum;
        logic [COORD_W-1:0] res;
        off = prod[MUL_P_W-1:DIR_FRAC];
        sum = (OFF_W+2)'(org) + (OFF_W+2)'(off);
        if (big) begin
            res = neg ? '0 : COORD_MAX;
        end else if (neg) begin
            res = (off > OFF_W'(org)) ? '0 : COORD_W'(OFF_W'(org) - off);
        end else begin
            res = (sum > (OFF_W+2)'(COORD_MAX)) ? COORD_MAX : sum[COORD_W-1:0];
        end
        return res;
    endfunction

    // Request registers
    logic                 r_mode;
    logic [3:0]           r_col, r_row;
    logic [ORG_W-1:0]     r_ox, r_oy;
    logic [DIR_W-1:0]     r_adx, r_ady;
    logic                 r_neg_x, r_neg_y;
    logic [LIMIT_W-1:0]   r_distance_limit;

    // Arithmetic units
    logic [MUL_A_W-1:0]   w_mul_a;
    logic [MUL_B_W-1:0]   w_mul_b;
    logic [MUL_P_W-1:0]   r_prod;
    logic [RAD_W-1:0]     r_sq, r_rad;
    logic [LEN_W+3:0]     r_rem;
    logic [LEN_W-1:0]     r_root;
    logic [LEN_W+3:0]     w_rem_sh, w_trial;
    logic [QUO_W-1:0]     r_num [2];
    logic [DIR_W-1:0]     r_drem [2];
    logic [QUO_W-1:0]     r_quo [2];
    logic [DIR_W-1:0]     w_den [2];
    logic [DIR_W:0]       w_drem_sh [2];

    // Walker
    logic [DIST_W-1:0]    r_lx, r_ly, r_dist;
    logic [DIST_W-1:0]    w_stx, w_sty;
    logic [DIST_W:0]      w_zlen_x, w_zlen_y;
    logic signed [CELL_W-1:0] r_cx, r_cy, w_cx_n, w_cy_n;
    logic signed [CELL_W-1:0] w_col, w_row;
    logic                 w_x_steps;
    logic [2*CELL_W-1:0]  w_lin;
    logic [AW-1:0]        w_addr, w_raddr;
    logic                 w_in_grid, w_border, w_rd_issue;
    logic [FRAC_BITS:0]   w_fx, w_fy;

    // Map store
    logic [DEPTH-1:0]     r_valid;
    logic                 r_rd_valid, r_rd_border, r_in_grid;
    logic [AW-1:0]        r_rd_addr;
    logic [KW-1:0]        w_ram_q, w_kind, w_kind_new;
    logic [KW+KIND_OUT_W-1:0] w_kind_ext, w_new_ext;
    logic [AW+IDX_W-1:0]  w_idx_ext;
    logic                 w_we;

    // Results
    logic                 r_res_hit;
    logic [IDX_W-1:0]     r_res_idx;
    logic [KIND_OUT_W-1:0] r_res_kind;
    logic [COORD_W-1:0]   r_res_hx, r_res_hy;
    logic                 r_out_hit;
    logic [IDX_W-1:0]     r_out_idx;
    logic [KIND_OUT_W-1:0] r_out_kind;
    logic [COORD_W-1:0]   r_out_hx, r_out_hy;
    logic                 w_big;

    // Distance limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_distance_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_distance_limit <= i_cfg_data;
        end
    end

    // Capture the request, keeping direction as sign and magnitude
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode  <= i_mode;
            r_col   <= i_cell_column;
            r_row   <= i_cell_row;
            r_ox    <= i_origin_x;
            r_oy    <= i_origin_y;
            r_neg_x <= i_dir_x[DIR_W-1];
            r_neg_y <= i_dir_y[DIR_W-1];
            r_adx   <= i_dir_x[DIR_W-1] ? DIR_W'(-i_dir_x) : DIR_W'(i_dir_x);
            r_ady   <= i_dir_y[DIR_W-1] ? DIR_W'(-i_dir_y) : DIR_W'(i_dir_y);
        end
    end

    // Shared multiplier operand select
    assign w_fx = r_neg_x ? {1'b0, r_ox[FRAC_BITS-1:0]} : FRAC_ONE - {1'b0, r_ox[FRAC_BITS-1:0]};
    assign w_fy = r_neg_y ? {1'b0, r_oy[FRAC_BITS-1:0]} : FRAC_ONE - {1'b0, r_oy[FRAC_BITS-1:0]};

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SQ_X: begin
                w_mul_a = r_adx;
                w_mul_b = MUL_B_W'(r_adx);
            end
            MUL_SQ_Y: begin
                w_mul_a = r_ady;
                w_mul_b = MUL_B_W'(r_ady);
            end
            MUL_FIRST_X: begin
                w_mul_a = MUL_A_W'(w_fx);
                w_mul_b = MUL_B_W'(r_quo[0]);
            end
            MUL_FIRST_Y: begin
                w_mul_a = MUL_A_W'(w_fy);
                w_mul_b = MUL_B_W'(r_quo[1]);
            end
            MUL_HIT_X: begin
                w_mul_a = r_adx;
                w_mul_b = r_dist[MUL_B_W-1:0];
            end
            MUL_HIT_Y: begin
                w_mul_a = r_ady;
                w_mul_b = r_dist[MUL_B_W-1:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);
    end

    // Square root, two radicand bits per cycle
    assign w_rem_sh = {r_rem[LEN_W+1:0], r_rad[RAD_W-1:RAD_W-2]};
    assign w_trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_save) begin
            r_sq <= r_prod[RAD_W-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_sq + r_prod[RAD_W-1:0];
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[LEN_W-2:0], 1'b0};
            end
        end
    end

    // Two-lane restoring divider: step length = (len << FRAC_BITS) / |d|
    assign w_den[0] = r_adx;
    assign w_den[1] = r_ady;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            w_drem_sh[i] = {r_drem[i], r_num[i][QUO_W-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 2; i++) begin
            if (i_cmd.div_init) begin
                r_num[i]  <= {r_root, {FRAC_BITS{1'b0}}};
                r_drem[i] <= '0;
                r_quo[i]  <= '0;
            end else if (i_cmd.div_step) begin
                r_num[i] <= {r_num[i][QUO_W-2:0], 1'b0};
                if (w_drem_sh[i] >= {1'b0, w_den[i]}) begin
                    r_drem[i] <= DIR_W'(w_drem_sh[i] - {1'b0, w_den[i]});
                    r_quo[i]  <= {r_quo[i][QUO_W-2:0], 1'b1};
                end else begin
                    r_drem[i] <= w_drem_sh[i][DIR_W-1:0];
                    r_quo[i]  <= {r_quo[i][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Cell walker
    assign w_stx     = (r_adx == '0) ? DIST_MAX : DIST_W'(r_quo[0]);
    assign w_sty     = (r_ady == '0) ? DIST_MAX : DIST_W'(r_quo[1]);
    assign w_x_steps = (r_lx < r_ly);
    assign w_cx_n    = !w_x_steps ? r_cx : (r_neg_x ? r_cx - CELL_W'(1) : r_cx + CELL_W'(1));
    assign w_cy_n    = w_x_steps ? r_cy : (r_neg_y ? r_cy - CELL_W'(1) : r_cy + CELL_W'(1));

    // Zero component: first length is the largest step scaled by the fraction
    assign w_zlen_x = {w_fx, {(DIST_W-FRAC_BITS){1'b0}}} - (DIST_W+1)'(1);
    assign w_zlen_y = {w_fy, {(DIST_W-FRAC_BITS){1'b0}}} - (DIST_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.first_x_save) begin
            r_lx <= (r_adx == '0) ? w_zlen_x[DIST_W-1:0] : DIST_W'(r_prod >> FRAC_BITS);
        end
        if (i_cmd.walk_init) begin
            r_ly   <= (r_ady == '0) ? w_zlen_y[DIST_W-1:0] : DIST_W'(r_prod >> FRAC_BITS);
            r_dist <= '0;
            r_cx   <= CELL_W'(r_ox[ORG_W-1:FRAC_BITS]);
            r_cy   <= CELL_W'(r_oy[ORG_W-1:FRAC_BITS]);
        end else if (i_cmd.step) begin
            r_cx <= w_cx_n;
            r_cy <= w_cy_n;
            if (w_x_steps) begin
                r_dist <= r_lx;
                r_lx   <= sat_add(r_lx, w_stx);
            end else begin
                r_dist <= r_ly;
                r_ly   <= sat_add(r_ly, w_sty);
            end
        end
    end

    // Map address of the edited or next walked cell
    assign w_col = i_cmd.edit_read ? CELL_W'(r_col) : w_cx_n;
    assign w_row = i_cmd.edit_read ? CELL_W'(r_row) : w_cy_n;
    assign w_in_grid = !w_col[CELL_W-1] && !w_row[CELL_W-1] &&
                       ($unsigned(w_col) < CELL_W'(MAP_COLS)) &&
                       ($unsigned(w_row) < CELL_W'(MAP_ROWS));
    assign w_border = (w_col == '0) || (w_row == '0) ||
                      ($unsigned(w_col) == CELL_W'(MAP_COLS - 1)) ||
                      ($unsigned(w_row) == CELL_W'(MAP_ROWS - 1));
    assign w_lin  = (2*CELL_W)'($unsigned(w_row)) * (2*CELL_W)'(MAP_COLS) +
                    (2*CELL_W)'($unsigned(w_col));
    assign w_addr = w_lin[AW-1:0];
    assign w_rd_issue = i_cmd.edit_read || i_cmd.step;
    // Hold the read address between issues so the read data stays on that cell
    assign w_raddr = w_rd_issue ? w_addr : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (w_rd_issue) begin
            r_rd_valid  <= r_valid[w_addr];
            r_rd_border <= w_border;
            r_in_grid   <= w_in_grid;
            r_rd_addr   <= w_addr;
        end
    end

    // Entries never edited read as their reset kind
    assign w_kind     = r_rd_valid ? w_ram_q : (r_rd_border ? KW'(1) : '0);
    assign w_kind_new = (w_kind == KW'(TILE_KINDS)) ? '0 : w_kind + KW'(1);
    assign w_kind_ext = {{KIND_OUT_W{1'b0}}, w_kind};
    assign w_new_ext  = {{KIND_OUT_W{1'b0}}, w_kind_new};
    assign w_idx_ext  = {{IDX_W{1'b0}}, r_rd_addr};
    assign w_we       = i_cmd.edit_write && r_in_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_rd_addr] <= 1'b1;
        end
    end

    gdrc_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_rd_addr),
        .i_wdata (w_kind_new),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    // Result staging
    assign w_big = (r_dist[DIST_W-1:MUL_B_W] != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.edit_write) begin
            r_res_hit  <= 1'b0;
            r_res_idx  <= r_in_grid ? w_idx_ext[IDX_W-1:0] : '0;
            r_res_kind <= r_in_grid ? w_new_ext[KIND_OUT_W-1:0] : '0;
            r_res_hx   <= '0;
            r_res_hy   <= '0;
        end else if (i_cmd.res_miss) begin
            r_res_hit  <= 1'b0;
            r_res_idx  <= '0;
            r_res_kind <= '0;
            r_res_hx   <= '0;
            r_res_hy   <= '0;
        end else if (i_cmd.hit_x_save) begin
            r_res_hit  <= 1'b1;
            r_res_idx  <= w_idx_ext[IDX_W-1:0];
            r_res_kind <= w_kind_ext[KIND_OUT_W-1:0];
            r_res_hx   <= hit_coord(r_ox, r_neg_x, w_big && (r_adx != '0), r_prod);
        end else if (i_cmd.hit_y_save) begin
            r_res_hy   <= hit_coord(r_oy, r_neg_y, w_big && (r_ady != '0), r_prod);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_hit  <= r_res_hit;
            r_out_idx  <= r_res_idx;
            r_out_kind <= r_res_kind;
            r_out_hx   <= r_res_hx;
            r_out_hy   <= r_res_hy;
        end
    end

    assign o_status.cast      = r_mode;
    assign o_status.at_limit  = (r_dist >= DIST_W'({r_distance_limit, {FRAC_BITS{1'b0}}}));
    assign o_status.hit_found = r_in_grid && (w_kind != '0);

    assign o_distance_limit = r_distance_limit;
    assign o_hit            = r_out_hit;
    assign o_hit_cell_index = r_out_idx;
    assign o_hit_kind       = r_out_kind;
    assign o_hit_x          = r_out_hx;
    assign o_hit_y          = r_out_hy;

endmodule

// ----- rtl/core/grid_dda_ray_caster_core.sv -----
// Top level of the grid ray caster: stream ports, register port, controller and datapath.
// Depends on gdrc_pkg, gdrc_ctrl, gdrc_datapath and gdrc_ram.
//
//   Channel  | Dir | Handshake                 | Carries
//   s_axis   | in  | tvalid / tready           | edit or cast request
//   m_axis   | out | tvalid / tready           | one result per request
//   apb      | in  | psel, penable, pwrite     | distance_limit at byte 0
//
// Edit: read the addressed cell, then write its next kind and finish.
// Cast: setup (square root in 16 steps, two-lane divider in 28 steps, multiplies and loads),
// then the cell walk with a map RAM read per cell stepped, then the hit multiplies on a hit;
// the walk loop over the map RAM read sets the rate.
// One request at a time; tready is high again once the result sits in the output register.
// A full output register stalls the finished request; reset is synchronous, active low.
`timescale 1ns / 1ps

module grid_dda_ray_caster_core #(
    parameter int MAP_COLS   = gdrc_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS   = gdrc_pkg::MAP_ROWS_DEF,
    parameter int TILE_KINDS = gdrc_pkg::TILE_KINDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cell_column[3:0], cell_row[7:4], origin_x[23:8], origin_y[39:24],
    // dir_x[55:40], dir_y[71:56]
    input  logic [gdrc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // mode[0]
    input  logic [0:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // hit_cell_index[7:0], hit_kind[9:8], hit_x[26:10], hit_y[43:27], zero[47:44]
    output logic [gdrc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // hit[0]
    output logic [0:0]                         o_m_axis_tuser,
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [gdrc_pkg::APB_AW-1:0]        i_paddr,
    input  logic [gdrc_pkg::APB_DW-1:0]        i_pwdata,
    output logic [gdrc_pkg::APB_DW-1:0]        o_prdata,
    output logic                               o_pready
);
    import gdrc_pkg::*;

    t_cmd                  w_cmd;
    t_status               w_status;
    logic                  w_cfg_we;
    logic                  w_reg_hit;
    logic [LIMIT_W-1:0]    w_limit;
    logic                  w_hit;
    logic [IDX_W-1:0]      w_idx;
    logic [KIND_OUT_W-1:0] w_kind;
    logic [COORD_W-1:0]    w_hx, w_hy;

    // Register decode
    assign o_pready  = 1'b1;
    assign w_reg_hit = (i_paddr[APB_AW-1:2] == REG_DIST_LIMIT);
    assign w_cfg_we  = i_psel && i_penable && i_pwrite && o_pready && w_reg_hit;
    assign o_prdata  = w_reg_hit ? APB_DW'(w_limit) : '0;

    gdrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gdrc_datapath #(
        .MAP_COLS   (MAP_COLS),
        .MAP_ROWS   (MAP_ROWS),
        .TILE_KINDS (TILE_KINDS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_mode           (i_s_axis_tuser[0]),
        .i_cell_column    (i_s_axis_tdata[3:0]),
        .i_cell_row       (i_s_axis_tdata[7:4]),
        .i_origin_x       (i_s_axis_tdata[23:8]),
        .i_origin_y       (i_s_axis_tdata[39:24]),
        .i_dir_x          (i_s_axis_tdata[55:40]),
        .i_dir_y          (i_s_axis_tdata[71:56]),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_data       (i_pwdata[LIMIT_W-1:0]),
        .o_distance_limit (w_limit),
        .o_hit            (w_hit),
        .o_hit_cell_index (w_idx),
        .o_hit_kind       (w_kind),
        .o_hit_x          (w_hx),
        .o_hit_y          (w_hy)
    );

    // Pack the result
    assign o_m_axis_tdata = {4'b0000, w_hy, w_hx, w_kind, w_idx};
    assign o_m_axis_tuser = w_hit;

endmodule

// ----- rtl/core/gdrc_checker.sv -----
// Port-level checks for the grid ray caster core, attached by bind.
// Depends on gdrc_pkg for port widths.
`timescale 1ns / 1ps

module gdrc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_axis_tvalid,
    input logic                             o_s_axis_tready,
    input logic [gdrc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [0:0]                       i_s_axis_tuser,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [gdrc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic [0:0]                       o_m_axis_tuser,
    input logic                             i_psel,
    input logic                             i_penable,
    input logic                             i_pwrite,
    input logic [gdrc_pkg::APB_AW-1:0]      i_paddr,
    input logic [gdrc_pkg::APB_DW-1:0]      i_pwdata,
    input logic [gdrc_pkg::APB_DW-1:0]      o_prdata,
    input logic                             o_pready
);
    import gdrc_pkg::*;

    // One request in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a request is in flight");

    // A result without a hit carries no intersection
    a_miss_no_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata[43:10] == '0))
        else $error("intersection on a result without a hit");

    // Result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
        (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result dropped or changed while stalled");

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind grid_dda_ray_caster_core gdrc_checker u_gdrc_checker (.*);
